// ----- rtl/core/shs_pkg.sv -----
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the streaming sha-256 hasher
// state codes, controller command bundle, initial hash and round constants
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ROUNDS   = 64;
  localparam int unsigned BLOCK_W  = 512;
  localparam int unsigned TOTAL_W  = 61;
  localparam int unsigned DIGEST_W = 64;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  // source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SEL_IN,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t byte_sel;
    logic [2:0] len_idx;
    logic      count_en;
    logic      load_work;
    logic      round_en;
    logic [5:0] round_idx;
    logic      update_en;
    logic      out_load;
    logic      reinit;
  } cmd_t;

  localparam logic [WORD_W-1:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

// ----- rtl/core/shs_ctrl.sv -----
// ----------------------------------------------------------------------------
// shs_ctrl: sequencer of the streaming sha-256 hasher
// byte gathering, padding, round count and digest hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module shs_ctrl
  import shs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_has_byte,
  input  wire logic in_end_message,
  output logic      in_stall,
  input  wire logic out_stall,
  output logic      out_valid,
  output cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] round_r, round_nxt;
  logic       end_pend_r, end_pend_nxt;
  logic       mark_r, mark_nxt;
  logic       len_r, len_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      fill_r      <= '0;
      round_r     <= '0;
      end_pend_r  <= 1'b0;
      mark_r      <= 1'b0;
      len_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      round_r     <= round_nxt;
      end_pend_r  <= end_pend_nxt;
      mark_r      <= mark_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    round_nxt    = round_r;
    end_pend_nxt = end_pend_r;
    mark_nxt     = mark_r;
    len_nxt      = len_r;
    cmd          = '0;
    cmd.byte_sel = SEL_IN;
    cmd.len_idx  = fill_r[2:0];
    cmd.round_idx = round_r;
    in_stall     = (state_r != ST_COLLECT);

    unique case (state_r)
      ST_COLLECT: begin
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.shift_en = 1'b1;
            cmd.count_en = 1'b1;
            fill_nxt     = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              // block full: compress first, pad afterwards if ending
              cmd.load_work = 1'b1;
              round_nxt     = '0;
              end_pend_nxt  = in_end_message;
              state_nxt     = ST_ROUND;
            end else if (in_end_message) begin
              end_pend_nxt = 1'b1;
              state_nxt    = ST_PAD;
            end
          end else if (in_end_message) begin
            end_pend_nxt = 1'b1;
            state_nxt    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        fill_nxt     = fill_r + 6'd1;
        if (!mark_r) begin
          cmd.byte_sel = SEL_MARK;
          mark_nxt     = 1'b1;
        end else if (len_r || fill_r == 6'd56) begin
          cmd.byte_sel = SEL_LEN;
          len_nxt      = 1'b1;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (fill_r == 6'd63) begin
          cmd.load_work = 1'b1;
          round_nxt     = '0;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update_en = 1'b1;
        if (len_r) begin
          state_nxt = ST_OUTPUT;
        end else if (end_pend_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_OUTPUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.reinit   = 1'b1;
          fill_nxt     = '0;
          end_pend_nxt = 1'b0;
          mark_nxt     = 1'b0;
          len_nxt      = 1'b0;
          state_nxt    = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/shs_datapath.sv -----
// ----------------------------------------------------------------------------
// shs_datapath: block window, message schedule, round unit and chain value
// one compression round per cycle, digest output register
// ----------------------------------------------------------------------------
`default_nettype none

module shs_datapath
  import shs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  input  wire logic [7:0]          in_data_byte,
  output logic      [DIGEST_W-1:0] out_digest_word_0,
  output logic      [DIGEST_W-1:0] out_digest_word_1,
  output logic      [DIGEST_W-1:0] out_digest_word_2,
  output logic      [DIGEST_W-1:0] out_digest_word_3
);

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // window word 0 is the oldest: w[t] during a round
  logic [BLOCK_W-1:0] win_r, win_nxt;
  logic [WORD_W-1:0]  work_r [8];
  logic [WORD_W-1:0]  work_nxt [8];
  logic [WORD_W-1:0]  chain_r [8];
  logic [WORD_W-1:0]  chain_nxt [8];
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [DIGEST_W-1:0] dig_r [4];

  logic [63:0]       len_bits;
  logic [7:0]        len_byte;
  logic [7:0]        shift_byte;
  logic [WORD_W-1:0] w0, w1, w9, w14, w_new;
  logic [WORD_W-1:0] t1, t2, ch, maj;

  assign len_bits = {total_r, 3'b000};
  assign len_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];

  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:   shift_byte = in_data_byte;
      SEL_MARK: shift_byte = PAD_MARK;
      SEL_LEN:  shift_byte = len_byte;
      default:  shift_byte = 8'h00;
    endcase
  end

  assign w0    = win_r[BLOCK_W-1 -: WORD_W];
  assign w1    = win_r[BLOCK_W-1-WORD_W -: WORD_W];
  assign w9    = win_r[BLOCK_W-1-9*WORD_W -: WORD_W];
  assign w14   = win_r[BLOCK_W-1-14*WORD_W -: WORD_W];
  assign w_new = w0 + ssig0(w1) + w9 + ssig1(w14);

  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + bsig1(work_r[4]) + ch + ROUND_K[cmd.round_idx] + w0;
  assign t2  = bsig0(work_r[0]) + maj;

  always_comb begin
    win_nxt   = win_r;
    total_nxt = total_r;
    for (int i = 0; i < 8; i++) begin
      work_nxt[i]  = work_r[i];
      chain_nxt[i] = chain_r[i];
    end

    if (cmd.shift_en) begin
      win_nxt = {win_r[BLOCK_W-9:0], shift_byte};
    end else if (cmd.round_en) begin
      win_nxt = {win_r[BLOCK_W-WORD_W-1:0], w_new};
    end

    if (cmd.count_en) begin
      total_nxt = total_r + TOTAL_W'(1);
    end

    if (cmd.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work_nxt[i] = chain_r[i];
      end
    end else if (cmd.round_en) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end

    if (cmd.update_en) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end else if (cmd.reinit) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = INIT_H[i];
      end
    end

    if (cmd.reinit) begin
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= INIT_H[i];
      end
    end else begin
      total_r <= total_nxt;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
    if (cmd.out_load) begin
      for (int i = 0; i < 4; i++) begin
        dig_r[i] <= {chain_r[2*i], chain_r[2*i+1]};
      end
    end
  end

  assign out_digest_word_0 = dig_r[0];
  assign out_digest_word_1 = dig_r[1];
  assign out_digest_word_2 = dig_r[2];
  assign out_digest_word_3 = dig_r[3];

endmodule

`default_nettype wire

// ----- rtl/core/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming sha-256 message hasher
// a message byte is taken per cycle while gathering; after every 64 bytes input
// stalls for the rounds in the round unit, one per cycle, and one chain update
// end item: pad bytes to the block end and a compression, plus a second padded
// block and compression when the length spills, then the digest register load
// synchronous active-low reset restores the initial hash and empties the block
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input item channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_has_byte,
  input  wire logic                in_end_message,
  // digest item channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [DIGEST_W-1:0] out_digest_word_0,
  output logic      [DIGEST_W-1:0] out_digest_word_1,
  output logic      [DIGEST_W-1:0] out_digest_word_2,
  output logic      [DIGEST_W-1:0] out_digest_word_3
);

  // command bundle from the sequencer to the datapath
  cmd_t cmd;

  // sequencer: owns fill count, round count, padding phase and out_valid;
  // input is only taken while gathering, and a waiting digest does not
  // block gathering of the next message
  shs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_has_byte    (in_has_byte),
    .in_end_message (in_end_message),
    .in_stall       (in_stall),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .cmd            (cmd)
  );

  // datapath: 512-bit byte window doubling as the 16-word schedule line,
  // working variables, chain value, byte total and digest register
  shs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_data_byte      (in_data_byte),
    .out_digest_word_0 (out_digest_word_0),
    .out_digest_word_1 (out_digest_word_1),
    .out_digest_word_2 (out_digest_word_2),
    .out_digest_word_3 (out_digest_word_3)
  );

endmodule

`default_nettype wire

// ----- rtl/core/shs_checker.sv -----
// ----------------------------------------------------------------------------
// shs_checker: port-level checks of the streaming sha-256 hasher
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module shs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_end_message,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_digest_word_0,
  input wire logic [63:0] out_digest_word_1,
  input wire logic [63:0] out_digest_word_2,
  input wire logic [63:0] out_digest_word_3
);

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word_0) &&
      $stable(out_digest_word_1) && $stable(out_digest_word_2) &&
      $stable(out_digest_word_3))
    else $error("stalled digest item changed");

  // an end item always starts padding or a compression, so input stalls next cycle
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_message |=> in_stall)
    else $error("input not stalled after end item");

  // a new digest only appears while input was stalled the cycle before
  a_digest_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("digest appeared while gathering");

  // reset leaves the block gathering with no digest pending
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("bad state after reset");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);

`default_nettype wire
